@@ design/aiff_sample_data_decoder_unit_defines.svh @@
// Assertion helpers shared by the decoder modules.
// Every macro expects clk and rst_n to be visible where it is used.
`ifndef AIFF_SAMPLE_DATA_DECODER_UNIT_DEFINES_SVH
`define AIFF_SAMPLE_DATA_DECODER_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define AIFFD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle is followed by another in the next.
`define AIFFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/aiffd_pkg.sv @@
`timescale 1ns / 1ps

package aiffd_pkg;

    // Classified operation carried from front to back
    typedef enum logic {
        OP_DATA = 1'b0,
        OP_SEEK = 1'b1
    } op_kind_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_DECODE_MODE   = 2'd0,
        REG_CHANNEL_COUNT = 2'd1,
        REG_WIDE_SAMPLES  = 2'd2,
        REG_TOTAL_FRAMES  = 2'd3
    } cfg_reg_t;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 32;

    // Queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_PTR_W = 1;
    localparam int unsigned QUEUE_CNT_W = 2;

    // SDX2 saturation limits and PCM8 bias
    localparam logic signed [16:0] SAT_HI    = 17'sd32767;
    localparam logic signed [16:0] SAT_LO    = -17'sd32768;
    localparam logic [7:0]         PCM8_BIAS = 8'd128;

    typedef struct packed {
        logic        decode_mode;
        logic [1:0]  channel_count;
        logic        wide_samples;
        logic [31:0] total_frames;
    } cfg_t;

    typedef struct packed {
        op_kind_t           kind;
        logic [7:0]         data_byte;
        logic signed [15:0] square;     // 2*s*|s| of the signed byte
        logic               odd;        // add previous value
        logic [31:0]        position;   // clamped seek frame
    } op_t;

endpackage

@@ design/aiffd_if.sv @@
`timescale 1ns / 1ps

// Input beat: one data byte or one seek request
interface aiffd_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  data_byte;
    logic [31:0] seek_frame;

    modport source (output valid, kind, data_byte, seek_frame, input ready);
    modport sink   (input valid, kind, data_byte, seek_frame, output ready);
endinterface

// Result beat: one sample or one seek reply
interface aiffd_out_if;
    logic        valid;
    logic        ready;
    logic        is_seek_reply;
    logic [15:0] sample_word;
    logic        channel_index;
    logic        frame_last;
    logic [31:0] position;

    modport source (output valid, is_seek_reply, sample_word, channel_index, frame_last,
                    position, input ready);
    modport sink   (input valid, is_seek_reply, sample_word, channel_index, frame_last,
                    position, output ready);
endinterface

// Configuration write beat
interface aiffd_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  reg_index;
    logic [31:0] write_data;

    modport source (output valid, reg_index, write_data, input ready);
    modport sink   (input valid, reg_index, write_data, output ready);
endinterface

@@ design/aiffd_front.sv @@
`timescale 1ns / 1ps

module aiffd_front (
    aiffd_in_if.sink        sample_in,
    input  logic [31:0]     total_frames,
    output logic            push_valid,
    input  logic            push_ready,
    output aiffd_pkg::op_t  push_entry
);

    logic signed [8:0]  s_val;
    logic signed [8:0]  s_mag;
    logic signed [17:0] s_prod;

    // Square the signed byte with its sign kept
    always_comb
    begin
        s_val  = signed'({sample_in.data_byte[7], sample_in.data_byte});
        s_mag  = s_val[8] ? -s_val : s_val;
        s_prod = s_val * s_mag;
    end

    // Classify the beat and clamp the seek target
    always_comb
    begin
        push_entry.kind      = sample_in.kind ? aiffd_pkg::OP_SEEK : aiffd_pkg::OP_DATA;
        push_entry.data_byte = sample_in.data_byte;
        push_entry.square    = signed'({s_prod[14:0], 1'b0});
        push_entry.odd       = sample_in.data_byte[0];
        push_entry.position  = (sample_in.seek_frame > total_frames) ? total_frames
                                                                     : sample_in.seek_frame;
    end

    assign push_valid      = sample_in.valid;
    assign sample_in.ready = push_ready;

endmodule

@@ design/aiffd_queue.sv @@
`timescale 1ns / 1ps
`include "aiff_sample_data_decoder_unit_defines.svh"

module aiffd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  aiffd_pkg::op_t  push_entry,
    output logic            pop_valid,
    input  logic            pop_ready,
    output aiffd_pkg::op_t  pop_entry
);

    aiffd_pkg::op_t                        slot_reg [aiffd_pkg::QUEUE_DEPTH];
    logic [aiffd_pkg::QUEUE_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [aiffd_pkg::QUEUE_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [aiffd_pkg::QUEUE_CNT_W-1:0]     count_reg, count_next;
    logic                                  push_fire, pop_fire;

    assign push_ready = (count_reg != aiffd_pkg::QUEUE_CNT_W'(aiffd_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push_fire ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop_fire ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + aiffd_pkg::QUEUE_CNT_W'(push_fire)
                                - aiffd_pkg::QUEUE_CNT_W'(pop_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed beat
    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `AIFFD_ASSERT(a_queue_bound, count_reg <= aiffd_pkg::QUEUE_CNT_W'(aiffd_pkg::QUEUE_DEPTH), "queue occupancy beyond depth")
    `AIFFD_ASSERT_NEXT(a_queue_count, 1'b1, count_reg == $past(count_next), "queue occupancy lost track")

endmodule

@@ design/aiffd_back.sv @@
`timescale 1ns / 1ps
`include "aiff_sample_data_decoder_unit_defines.svh"

module aiffd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  aiffd_pkg::cfg_t   cfg_regs,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  aiffd_pkg::op_t    pop_entry,
    aiffd_out_if.source       sample_out
);

    // Decoder state
    logic [15:0] prev_reg [2];
    logic [15:0] prev_next [2];
    logic        chan_phase_reg, chan_phase_next;
    logic        byte_phase_reg, byte_phase_next;
    logic [7:0]  held_reg, held_next;
    logic [31:0] frame_count_reg, frame_count_next;

    // Output register
    logic        out_valid_reg, out_valid_next;
    logic        is_seek_reg, is_seek_next;
    logic [15:0] sample_reg, sample_next;
    logic        chan_out_reg, chan_out_next;
    logic        last_reg, last_next;
    logic [31:0] pos_reg, pos_next;

    logic               take;
    logic               emit;
    logic               last;
    logic signed [15:0] prev_sel;
    logic signed [16:0] sdx2_sum;
    logic [15:0]        sdx2_word;

    // Take a queued beat whenever the output slot is free or draining
    assign pop_ready = !out_valid_reg || sample_out.ready;
    assign take      = pop_valid && pop_ready;

    // Add the previous value on odd bytes and saturate
    always_comb
    begin
        prev_sel = signed'(prev_reg[chan_phase_reg]);
        sdx2_sum = 17'(pop_entry.square) + (pop_entry.odd ? 17'(prev_sel) : 17'sd0);
        if (sdx2_sum > aiffd_pkg::SAT_HI)
        begin
            sdx2_word = aiffd_pkg::SAT_HI[15:0];
        end
        else if (sdx2_sum < aiffd_pkg::SAT_LO)
        begin
            sdx2_word = aiffd_pkg::SAT_LO[15:0];
        end
        else
        begin
            sdx2_word = sdx2_sum[15:0];
        end
    end

    // Execute the beat: seek, drop past end, or decode
    always_comb
    begin
        prev_next        = prev_reg;
        chan_phase_next  = chan_phase_reg;
        byte_phase_next  = byte_phase_reg;
        held_next        = held_reg;
        frame_count_next = frame_count_reg;
        is_seek_next     = is_seek_reg;
        sample_next      = sample_reg;
        chan_out_next    = chan_out_reg;
        last_next        = last_reg;
        pos_next         = pos_reg;
        emit             = 1'b0;
        last             = chan_phase_reg || (cfg_regs.channel_count <= 2'd1);

        if (take)
        begin
            unique case (pop_entry.kind)
                aiffd_pkg::OP_SEEK:
                begin
                    emit             = 1'b1;
                    frame_count_next = pop_entry.position;
                    prev_next[0]     = '0;
                    prev_next[1]     = '0;
                    chan_phase_next  = 1'b0;
                    byte_phase_next  = 1'b0;
                    held_next        = '0;
                    is_seek_next     = 1'b1;
                    sample_next      = '0;
                    chan_out_next    = 1'b0;
                    last_next        = 1'b0;
                    pos_next         = pop_entry.position;
                end
                aiffd_pkg::OP_DATA:
                begin
                    if (frame_count_reg < cfg_regs.total_frames)
                    begin
                        priority if (cfg_regs.decode_mode)
                        begin
                            emit                      = 1'b1;
                            sample_next               = sdx2_word;
                            prev_next[chan_phase_reg] = sdx2_word;
                        end
                        else if (cfg_regs.wide_samples)
                        begin
                            if (!byte_phase_reg)
                            begin
                                held_next       = pop_entry.data_byte;
                                byte_phase_next = 1'b1;
                            end
                            else
                            begin
                                emit            = 1'b1;
                                byte_phase_next = 1'b0;
                                sample_next     = {held_reg, pop_entry.data_byte};
                            end
                        end
                        else
                        begin
                            emit        = 1'b1;
                            sample_next = {8'd0, pop_entry.data_byte + aiffd_pkg::PCM8_BIAS};
                        end

                        // Advance channel and frame on a produced sample
                        if (emit)
                        begin
                            is_seek_next  = 1'b0;
                            chan_out_next = chan_phase_reg;
                            last_next     = last;
                            if (last)
                            begin
                                chan_phase_next  = 1'b0;
                                frame_count_next = frame_count_reg + 32'd1;
                            end
                            else
                            begin
                                chan_phase_next = 1'b1;
                            end
                            pos_next = last ? frame_count_reg + 32'd1 : frame_count_reg;
                        end
                    end
                end
            endcase
        end

        if (take)
        begin
            out_valid_next = emit;
        end
        else if (sample_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg[0]     <= '0;
            prev_reg[1]     <= '0;
            chan_phase_reg  <= 1'b0;
            byte_phase_reg  <= 1'b0;
            held_reg        <= '0;
            frame_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            prev_reg        <= prev_next;
            chan_phase_reg  <= chan_phase_next;
            byte_phase_reg  <= byte_phase_next;
            held_reg        <= held_next;
            frame_count_reg <= frame_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Hold the result payload until taken
    always_ff @(posedge clk)
    begin
        is_seek_reg  <= is_seek_next;
        sample_reg   <= sample_next;
        chan_out_reg <= chan_out_next;
        last_reg     <= last_next;
        pos_reg      <= pos_next;
    end

    assign sample_out.valid         = out_valid_reg;
    assign sample_out.is_seek_reply = is_seek_reg;
    assign sample_out.sample_word   = sample_reg;
    assign sample_out.channel_index = chan_out_reg;
    assign sample_out.frame_last    = last_reg;
    assign sample_out.position      = pos_reg;

    `AIFFD_ASSERT(a_seek_reply_clean, !(out_valid_reg && is_seek_reg) || (sample_reg == '0 && !chan_out_reg && !last_reg), "seek reply carries sample fields")
    `AIFFD_ASSERT_NEXT(a_seek_resets_phase, take && pop_entry.kind == aiffd_pkg::OP_SEEK, out_valid_reg && !chan_phase_reg && !byte_phase_reg, "seek left phase state behind")
    `AIFFD_ASSERT_NEXT(a_frame_step, take && pop_entry.kind == aiffd_pkg::OP_DATA, frame_count_reg == $past(frame_count_reg) || frame_count_reg == $past(frame_count_reg) + 32'd1, "frame count jumped on a data byte")

endmodule

@@ design/aiff_sample_data_decoder_unit.sv @@
`timescale 1ns / 1ps
// Channel      Dir   Beat
// sample_in    in    kind, data_byte, seek_frame: one byte or one seek request
// sample_out   out   is_seek_reply, sample_word, channel_index, frame_last, position
// cfg          in    reg_index, write_data: one register write, always ready
//
// One beat is accepted per cycle while the queue has room; a result passes through the
// front/back queue and the output register. The back decodes one queued beat per cycle
// unless the output register stalls: one multiply in the front, one add and saturate in
// the back. A two-entry queue lets the front keep accepting while the output register
// stalls; sample_in.ready drops only when the queue is full.
// rst_n clears all decoder state, the queue and the output valid at once.

module aiff_sample_data_decoder_unit (
    input  logic         clk,
    input  logic         rst_n,
    aiffd_in_if.sink     sample_in,
    aiffd_out_if.source  sample_out,
    aiffd_cfg_if.sink    cfg
);

    aiffd_pkg::cfg_t cfg_regs_reg;
    logic            push_valid, push_ready;
    logic            pop_valid, pop_ready;
    aiffd_pkg::op_t  push_entry, pop_entry;

    // Accept register writes every cycle
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_regs_reg.decode_mode   <= 1'b0;
            cfg_regs_reg.channel_count <= 2'd1;
            cfg_regs_reg.wide_samples  <= 1'b1;
            cfg_regs_reg.total_frames  <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (aiffd_pkg::cfg_reg_t'(cfg.reg_index))
                aiffd_pkg::REG_DECODE_MODE:   cfg_regs_reg.decode_mode   <= cfg.write_data[0];
                aiffd_pkg::REG_CHANNEL_COUNT: cfg_regs_reg.channel_count <= cfg.write_data[1:0];
                aiffd_pkg::REG_WIDE_SAMPLES:  cfg_regs_reg.wide_samples  <= cfg.write_data[0];
                aiffd_pkg::REG_TOTAL_FRAMES:  cfg_regs_reg.total_frames  <= cfg.write_data;
            endcase
        end
    end

    aiffd_front u_front (
        .sample_in    (sample_in),
        .total_frames (cfg_regs_reg.total_frames),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_entry   (push_entry)
    );

    aiffd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    aiffd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_regs   (cfg_regs_reg),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry),
        .sample_out (sample_out)
    );

endmodule

@@ dv/tb_aiff_sample_data_decoder_unit.sv @@
`timescale 1ns / 1ps

module tb_aiff_sample_data_decoder_unit;

    // One decoded sample or seek reply as it leaves the block
    typedef struct {
        logic        is_seek_reply;
        logic [15:0] sample_word;
        logic        channel_index;
        logic        frame_last;
        logic [31:0] position;
    } decoded_beat_t;

    logic clk;
    logic rst_n;

    aiffd_in_if  in_ch ();
    aiffd_out_if out_ch ();
    aiffd_cfg_if cfg_ch ();

    aiff_sample_data_decoder_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (in_ch),
        .sample_out (out_ch),
        .cfg        (cfg_ch)
    );

    // Mirror of the configuration registers
    logic        mode_sdx2;
    logic [1:0]  chan_setting;
    logic        wide_pcm;
    logic [31:0] frame_limit;

    // Mirror of the decoder state
    logic [15:0] last_word [2];
    logic        chan_phase;
    logic        hi_phase;
    logic [7:0]  held_hi;
    logic [31:0] frames_done;

    decoded_beat_t pending_samples [$];
    int            err_count;
    bit            idling_on;

    // Free-running clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Work out the result of one accepted beat; returns 0 when there is none
    function automatic bit decode_beat(input aiffd_pkg::op_kind_t kind, input logic [7:0] b,
                                       input logic [31:0] seek, output decoded_beat_t r);
        logic signed [7:0] sb;
        int                sv;
        int                mag;
        int                acc;
        logic              ch;
        logic [15:0]       word;
        logic              last;
        int                chans;

        r = '{default: '0};
        if (kind == aiffd_pkg::OP_SEEK) begin
            r.is_seek_reply = 1'b1;
            r.position      = (seek > frame_limit) ? frame_limit : seek;
            frames_done     = r.position;
            last_word[0]    = '0;
            last_word[1]    = '0;
            chan_phase      = 1'b0;
            hi_phase        = 1'b0;
            held_hi         = '0;
            return 1'b1;
        end

        // End of stream: drop the byte
        if (frames_done >= frame_limit)
            return 1'b0;

        ch = chan_phase;
        if (mode_sdx2) begin
            sb  = b;
            sv  = sb;
            mag = (sv < 0) ? -sv : sv;
            acc = 2 * sv * mag;
            if (b[0])
                acc = acc + int'($signed(last_word[ch]));
            if (acc > aiffd_pkg::SAT_HI)
                acc = aiffd_pkg::SAT_HI;
            else if (acc < aiffd_pkg::SAT_LO)
                acc = aiffd_pkg::SAT_LO;
            word          = acc[15:0];
            last_word[ch] = word;
        end else if (wide_pcm) begin
            // Hold the high byte until the low byte arrives
            if (!hi_phase) begin
                held_hi  = b;
                hi_phase = 1'b1;
                return 1'b0;
            end
            hi_phase = 1'b0;
            word     = {held_hi, b};
        end else begin
            word = {8'h00, b + aiffd_pkg::PCM8_BIAS};
        end

        chans = (chan_setting <= 2'd1) ? 1 : 2;
        last  = (int'(ch) + 1 >= chans);
        if (last) begin
            chan_phase  = 1'b0;
            frames_done = frames_done + 32'd1;
        end else begin
            chan_phase = 1'b1;
        end

        r.sample_word   = word;
        r.channel_index = ch;
        r.frame_last    = last;
        r.position      = frames_done;
        return 1'b1;
    endfunction

    // Send one beat, with an optional idle burst ahead of it
    task automatic send_beat(input aiffd_pkg::op_kind_t kind, input logic [7:0] b,
                             input logic [31:0] seek);
        decoded_beat_t r;

        @(negedge clk);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.kind       <= kind;
        in_ch.data_byte  <= b;
        in_ch.seek_frame <= seek;
        do
            @(posedge clk);
        while (!in_ch.ready);
        if (decode_beat(kind, b, seek, r))
            pending_samples.push_back(r);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_beat(aiffd_pkg::OP_DATA, b, $urandom());
    endtask

    task automatic send_seek(input logic [31:0] f);
        send_beat(aiffd_pkg::OP_SEEK, 8'($urandom_range(0, 255)), f);
    endtask

    // Drop valid, drain every expected result, then let queued no-result beats clear
    task automatic settle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // Write one register while the block is idle
    task automatic write_reg(input aiffd_pkg::cfg_reg_t idx, input logic [31:0] data);
        settle();
        @(negedge clk);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.reg_index  <= idx;
        cfg_ch.write_data <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            aiffd_pkg::REG_DECODE_MODE:   mode_sdx2    = data[0];
            aiffd_pkg::REG_CHANNEL_COUNT: chan_setting = data[1:0];
            aiffd_pkg::REG_WIDE_SAMPLES:  wide_pcm     = data[0];
            aiffd_pkg::REG_TOTAL_FRAMES:  frame_limit  = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_config(input logic mode, input logic [1:0] chans, input logic wide,
                              input logic [31:0] total);
        write_reg(aiffd_pkg::REG_DECODE_MODE, {31'd0, mode});
        write_reg(aiffd_pkg::REG_CHANNEL_COUNT, {30'd0, chans});
        write_reg(aiffd_pkg::REG_WIDE_SAMPLES, {31'd0, wide});
        write_reg(aiffd_pkg::REG_TOTAL_FRAMES, total);
    endtask

    // Reset settings: every byte is past the end, a seek clamps to zero
    task automatic test_end_of_stream();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_seek(32'hFFFF_FFFF);
        send_byte(8'h5A);
    endtask

    // 16-bit PCM, two channels, seeks inside and past the stream
    task automatic test_pcm16();
        set_config(1'b0, 2'd2, 1'b1, 32'd8);
        send_byte(8'h80);
        send_byte(8'h00);
        send_byte(8'h7F);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_seek(32'd5);
        send_byte(8'h00);
        send_byte(8'h01);
        send_seek(32'hFFFF_FFFF);
        send_byte(8'h12);
    endtask

    // 8-bit PCM up to the last frame of a maximal stream
    task automatic test_pcm8();
        set_config(1'b0, 2'd1, 1'b0, 32'hFFFF_FFFF);
        send_byte(8'h00);
        send_byte(8'h7F);
        send_byte(8'h80);
        send_byte(8'hFF);
        send_seek(32'hFFFF_FFFE);
        send_byte(8'h33);
        send_byte(8'h44);
    endtask

    // SDX2 extremes: odd bytes accumulate and saturate, even bytes restart
    task automatic test_sdx2();
        set_config(1'b1, 2'd2, 1'b1, 32'd100);
        send_seek(32'd0);
        send_byte(8'h7F);
        send_byte(8'h81);
        send_byte(8'h7F);
        send_byte(8'h81);
        send_byte(8'h80);
        send_byte(8'h01);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h7F);
        send_seek(32'd3);
        send_byte(8'h03);
    endtask

    // SDX2 with the 8-bit setting leaves a held PCM high byte alone
    task automatic test_sdx2_narrow();
        set_config(1'b0, 2'd1, 1'b1, 32'd50);
        send_byte(8'hA5);
        write_reg(aiffd_pkg::REG_DECODE_MODE, 32'd1);
        write_reg(aiffd_pkg::REG_WIDE_SAMPLES, 32'd0);
        send_byte(8'h45);
        send_byte(8'hC3);
        write_reg(aiffd_pkg::REG_DECODE_MODE, 32'd0);
        write_reg(aiffd_pkg::REG_WIDE_SAMPLES, 32'd1);
        send_byte(8'h5A);
    endtask

    // Channel count codes 0 and 3, and a count lowered in mid-frame
    task automatic test_channel_count();
        set_config(1'b0, 2'd0, 1'b0, 32'd40);
        send_byte(8'h11);
        send_byte(8'h22);
        write_reg(aiffd_pkg::REG_CHANNEL_COUNT, 32'd3);
        send_byte(8'h33);
        write_reg(aiffd_pkg::REG_CHANNEL_COUNT, 32'd1);
        send_byte(8'h44);
        send_byte(8'h55);
    endtask

    // Random phases: random settings, mostly data bytes, a few seeks
    task automatic test_random_stream();
        logic [31:0] total;
        logic [31:0] start;
        int          back;
        int          r;

        for (int phase = 0; phase < 14; phase++) begin
            idling_on = (phase < 12);
            case ($urandom_range(0, 3))
                0:       total = $urandom_range(0, 30);
                1:       total = $urandom();
                2:       total = 32'hFFFF_FFFF;
                default: total = $urandom_range(200, 2000);
            endcase
            write_reg(aiffd_pkg::REG_DECODE_MODE,
                      {$urandom()} & 32'hFFFF_FFFE | $urandom_range(0, 1));
            write_reg(aiffd_pkg::REG_CHANNEL_COUNT,
                      {$urandom()} & 32'hFFFF_FFFC | $urandom_range(0, 3));
            write_reg(aiffd_pkg::REG_WIDE_SAMPLES,
                      {$urandom()} & 32'hFFFF_FFFE | $urandom_range(0, 1));
            write_reg(aiffd_pkg::REG_TOTAL_FRAMES, total);

            // Start near the end of the stream, or at its head
            back  = $urandom_range(0, 40);
            start = (frame_limit > back) ? frame_limit - back : 32'd0;
            if ($urandom_range(0, 2) == 0)
                start = 32'd0;
            send_seek(start);

            for (int i = 0; i < 50; i++) begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    send_seek($urandom());
                else if (r < 6)
                    send_seek($urandom_range(0, 64));
                else
                    send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Output stall bursts
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (idling_on && $urandom_range(0, 4) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge clk) begin
        decoded_beat_t e;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_samples.size() == 0) begin
                $error("unexpected result beat: position %0d", out_ch.position);
                err_count++;
            end else begin
                e = pending_samples.pop_front();
                if (out_ch.is_seek_reply !== e.is_seek_reply) begin
                    $error("is_seek_reply: expected %0d, actual %0d",
                           e.is_seek_reply, out_ch.is_seek_reply);
                    err_count++;
                end
                if (out_ch.sample_word !== e.sample_word) begin
                    $error("sample_word: expected %h, actual %h",
                           e.sample_word, out_ch.sample_word);
                    err_count++;
                end
                if (out_ch.channel_index !== e.channel_index) begin
                    $error("channel_index: expected %0d, actual %0d",
                           e.channel_index, out_ch.channel_index);
                    err_count++;
                end
                if (out_ch.frame_last !== e.frame_last) begin
                    $error("frame_last: expected %0d, actual %0d",
                           e.frame_last, out_ch.frame_last);
                    err_count++;
                end
                if (out_ch.position !== e.position) begin
                    $error("position: expected %0d, actual %0d",
                           e.position, out_ch.position);
                    err_count++;
                end
            end
        end
    end

    // Hard stop if the run hangs
    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Reset, then run the tests in turn
    initial begin
        err_count         = 0;
        idling_on         = 1'b1;
        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.kind        = aiffd_pkg::OP_DATA;
        in_ch.data_byte   = '0;
        in_ch.seek_frame  = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.reg_index  = aiffd_pkg::REG_DECODE_MODE;
        cfg_ch.write_data = '0;

        mode_sdx2    = 1'b0;
        chan_setting = 2'd1;
        wide_pcm     = 1'b1;
        frame_limit  = '0;
        last_word[0] = '0;
        last_word[1] = '0;
        chan_phase   = 1'b0;
        hi_phase     = 1'b0;
        held_hi      = '0;
        frames_done  = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_end_of_stream();
        test_pcm16();
        test_pcm8();
        test_sdx2();
        test_sdx2_narrow();
        test_channel_count();
        test_random_stream();

        settle();
        repeat (20) @(posedge clk);
        if (err_count == 0 && pending_samples.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
